[rtl/core/stok_pkg.sv]
// Shared types and codes for the source tokenizer.
// No dependencies.
package stok_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_ESC,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BSTAR,
    MODE_PEND
  } mode_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_HEX,
    BASE_BIN
  } base_t;

  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_INT    = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_PUNCT  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  localparam logic [2:0] ERR_OPEN_COMMENT = 3'd0;
  localparam logic [2:0] ERR_OPEN_STRING  = 3'd1;
  localparam logic [2:0] ERR_CONTROL      = 3'd2;
  localparam logic [2:0] ERR_ESCAPE       = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN      = 3'd4;

  localparam logic [7:0] CTRL_MAX  = 8'h1f;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_EQ     = 8'h3d;

endpackage

[rtl/core/stok_in_if.sv]
// Source byte channel: valid/ready with one byte or the end mark per beat.
// Depends on nothing.
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       is_end;

  modport source (output valid, src_byte, is_end, input ready);
  modport sink   (input valid, src_byte, is_end, output ready);
endinterface

[rtl/core/stok_out_if.sv]
// Token channel: valid/ready with one token record per beat.
// Offset widths follow OFFSET_BITS.
interface stok_out_if #(parameter int OFFSET_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic [2:0]             tok_kind;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [OFFSET_BITS-1:0] tok_length;
  logic [63:0]            int_value;
  logic [7:0]             punct_first;
  logic [7:0]             punct_second;
  logic [OFFSET_BITS:0]   line_number;
  logic [OFFSET_BITS-1:0] line_begin;
  logic [2:0]             error_code;
  logic                   last;

  modport source (output valid, tok_kind, tok_start, tok_length, int_value, punct_first,
                  punct_second, line_number, line_begin, error_code, last, input ready);
  modport sink   (input valid, tok_kind, tok_start, tok_length, int_value, punct_first,
                  punct_second, line_number, line_begin, error_code, last, output ready);
endinterface

[rtl/core/stok_rq.sv]
// Four-entry token queue: takes up to two records per cycle, gives one per beat.
// Depends on nothing.
module stok_rq #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       wr_n,
  input  logic [WIDTH-1:0] wr_data0,
  input  logic [WIDTH-1:0] wr_data1,
  output logic             room2,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [4];
  logic [1:0]       wp;
  logic [1:0]       rp;
  logic [2:0]       count;
  logic             pop;

  assign rd_valid = count != 3'd0;
  assign pop      = rd_valid && rd_ready;
  assign room2    = count <= 3'd2;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem[wp] <= wr_data0;
    end
    if (wr_n == 2'd2) begin
      mem[wp + 2'd1] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + wr_n;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, wr_n} - {2'b0, pop};
    end
  end

endmodule

[rtl/core/source_tokenizer.sv]
// Streaming tokenizer top level: lexer state, per-byte step logic and the token queue.
// Depends on stok_pkg, stok_in_if, stok_out_if and stok_rq.
//
// One source byte (or the end mark) is taken per clock; the whole lexer step for it
// is combinational from the state registers into a four-entry token queue, so a
// byte is accepted whenever at least two queue entries are free. A byte that closes
// one token and opens another yields two tokens, which drain at one per beat; the
// sustained rate is one byte per cycle while the sink keeps up. After the end token
// or an error token the block accepts and drops all bytes until reset.
module source_tokenizer #(
  parameter int OFFSET_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  stok_in_if.sink               src,
  stok_out_if.source            tok
);

  localparam int OB = OFFSET_BITS;

  typedef struct packed {
    logic [2:0]    kind;
    logic [OB-1:0] start;
    logic [OB-1:0] length;
    logic [63:0]   value;
    logic [7:0]    p1;
    logic [7:0]    p2;
    logic [OB:0]   line;
    logic [OB-1:0] line_begin;
    logic [2:0]    err;
    logic          last;
  } rec_t;

  stok_pkg::mode_t mode, mode_next;
  stok_pkg::base_t base, base_next;
  logic [7:0]    held_byte, held_byte_next;
  logic [OB-1:0] token_begin, token_begin_next;
  logic [OB-1:0] token_len, token_len_next;
  logic [63:0]   number_acc, number_acc_next;
  logic [OB:0]   line_count, line_count_next;
  logic [OB-1:0] line_offset, line_offset_next;
  logic [OB-1:0] byte_offset;
  logic [OB:0]   token_line, token_line_next;
  logic [OB-1:0] token_line_begin, token_line_begin_next;
  logic          halted, halted_next;

  logic          accept;
  logic          room2;
  logic [7:0]    b;
  logic          is_end;
  logic [1:0]    wr_n;
  rec_t          rec0, rec1, rd_rec;

  logic          is_alpha, is_digit, is_ws, is_pend, is_single;
  logic [3:0]    dig;
  logic          dig_ok;
  logic [63:0]   acc_step;
  logic [OB-1:0] len_inc;

  // fresh-start results
  stok_pkg::mode_t f_mode;
  logic          f_emit, f_halt, f_nl, f_num;
  logic [2:0]    f_kind, f_err;
  logic [OB-1:0] f_len;
  logic [7:0]    f_p1;

  // results of the token in progress
  logic          do_fresh;
  logic          o_emit;
  logic [2:0]    o_kind, o_err;
  logic [OB-1:0] o_len;
  logic [63:0]   o_val;
  logic [7:0]    o_p1, o_p2;
  logic          o_nl;

  assign b      = src.src_byte;
  assign is_end = src.is_end;
  assign src.ready = room2;
  assign accept = src.valid && room2;

  assign is_alpha  = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  assign is_digit  = b >= "0" && b <= "9";
  assign is_ws     = b == " " || (b >= 8'h09 && b <= 8'h0d);
  assign is_pend   = b == "=" || b == "!" || b == "<" || b == ">" || b == "/";
  assign is_single = b == ";" || b == "(" || b == ")" || b == "{" || b == "}" ||
                     b == "+" || b == "-" || b == "[" || b == "]" || b == "*" ||
                     b == "%" || b == ",";
  assign len_inc   = token_len + {{(OB-1){1'b0}}, 1'b1};

  always_comb begin
    dig    = 4'd0;
    dig_ok = 1'b0;
    case (base)
      stok_pkg::BASE_HEX: begin
        if (is_digit) begin
          dig = 4'(b - "0"); dig_ok = 1'b1;
        end else if (b >= "a" && b <= "f") begin
          dig = 4'(b - 8'd87); dig_ok = 1'b1;
        end else if (b >= "A" && b <= "F") begin
          dig = 4'(b - 8'd55); dig_ok = 1'b1;
        end
      end
      stok_pkg::BASE_BIN: begin
        dig    = {3'd0, b[0]};
        dig_ok = b == "0" || b == "1";
      end
      default: begin
        dig    = 4'(b - "0");
        dig_ok = is_digit;
      end
    endcase
    dig_ok = dig_ok && !is_end;
    case (base)
      stok_pkg::BASE_HEX: acc_step = {number_acc[59:0], dig};
      stok_pkg::BASE_BIN: acc_step = {number_acc[62:0], dig[0]};
      default:            acc_step = {number_acc[60:0], 3'd0} + {number_acc[62:0], 1'b0} +
                                     {60'd0, dig};
    endcase
  end

  always_comb begin
    f_mode = stok_pkg::MODE_IDLE;
    f_emit = 1'b0;
    f_halt = 1'b0;
    f_nl   = 1'b0;
    f_num  = 1'b0;
    f_kind = stok_pkg::KIND_PUNCT;
    f_err  = stok_pkg::ERR_OPEN_COMMENT;
    f_len  = '0;
    f_p1   = 8'd0;
    if (is_end) begin
      f_emit = 1'b1;
      f_halt = 1'b1;
      f_kind = stok_pkg::KIND_END;
    end else if (b == stok_pkg::CH_HASH) begin
      f_mode = stok_pkg::MODE_LINE;
    end else if (is_ws) begin
      f_nl = b == 8'h0a;
    end else if (is_alpha || b == stok_pkg::CH_UNDER) begin
      f_mode = stok_pkg::MODE_IDENT;
      f_len  = {{(OB-1){1'b0}}, 1'b1};
    end else if (is_digit) begin
      f_mode = stok_pkg::MODE_NUMBER;
      f_num  = 1'b1;
      f_len  = {{(OB-1){1'b0}}, 1'b1};
    end else if (b == "\"") begin
      f_mode = stok_pkg::MODE_STRING;
      f_len  = {{(OB-1){1'b0}}, 1'b1};
    end else if (is_pend) begin
      f_mode = stok_pkg::MODE_PEND;
    end else if (is_single) begin
      f_emit = 1'b1;
      f_kind = stok_pkg::KIND_PUNCT;
      f_p1   = b;
    end else begin
      f_emit = 1'b1;
      f_halt = 1'b1;
      f_kind = stok_pkg::KIND_ERROR;
      f_err  = stok_pkg::ERR_UNKNOWN;
    end
  end

  always_comb begin
    mode_next      = mode;
    base_next      = base;
    token_len_next = token_len;
    number_acc_next = number_acc;
    halted_next    = halted;
    do_fresh       = 1'b0;
    o_emit         = 1'b0;
    o_kind         = stok_pkg::KIND_ERROR;
    o_err          = stok_pkg::ERR_OPEN_COMMENT;
    o_len          = '0;
    o_val          = 64'd0;
    o_p1           = 8'd0;
    o_p2           = 8'd0;
    o_nl           = 1'b0;
    case (mode)
      stok_pkg::MODE_IDENT: begin
        if (!is_end && (is_alpha || is_digit || b == stok_pkg::CH_UNDER)) begin
          token_len_next = len_inc;
        end else begin
          o_emit = 1'b1; o_kind = stok_pkg::KIND_IDENT; o_len = token_len;
          do_fresh = 1'b1;
        end
      end
      stok_pkg::MODE_NUMBER: begin
        if (!is_end && base == stok_pkg::BASE_DEC && token_len == {{(OB-1){1'b0}}, 1'b1} &&
            number_acc == 64'd0 && (b == "x" || b == "b")) begin
          base_next      = (b == "x") ? stok_pkg::BASE_HEX : stok_pkg::BASE_BIN;
          token_len_next = OB'(2);
        end else if (dig_ok) begin
          number_acc_next = acc_step;
          token_len_next  = len_inc;
        end else begin
          o_emit = 1'b1; o_kind = stok_pkg::KIND_INT; o_len = token_len; o_val = number_acc;
          do_fresh = 1'b1;
        end
      end
      stok_pkg::MODE_STRING: begin
        if (is_end) begin
          o_emit = 1'b1; o_err = stok_pkg::ERR_OPEN_STRING; halted_next = 1'b1;
          mode_next = stok_pkg::MODE_IDLE;
        end else if (b == "\"") begin
          token_len_next = len_inc;
          o_emit = 1'b1; o_kind = stok_pkg::KIND_STRING; o_len = len_inc;
          mode_next = stok_pkg::MODE_IDLE;
        end else if (b <= stok_pkg::CTRL_MAX) begin
          o_emit = 1'b1; o_err = stok_pkg::ERR_CONTROL; halted_next = 1'b1;
          mode_next = stok_pkg::MODE_IDLE;
        end else begin
          if (b == stok_pkg::CH_BSLASH) mode_next = stok_pkg::MODE_ESC;
          token_len_next = len_inc;
        end
      end
      stok_pkg::MODE_ESC: begin
        if (!is_end && (b == stok_pkg::CH_BSLASH || b == "\"" || b == "n" || b == "t")) begin
          token_len_next = len_inc;
          mode_next = stok_pkg::MODE_STRING;
        end else begin
          o_emit = 1'b1; o_err = stok_pkg::ERR_ESCAPE; halted_next = 1'b1;
          mode_next = stok_pkg::MODE_IDLE;
        end
      end
      stok_pkg::MODE_LINE: begin
        do_fresh = is_end || b == 8'h0a;
      end
      stok_pkg::MODE_BLOCK, stok_pkg::MODE_BSTAR: begin
        if (is_end) begin
          o_emit = 1'b1; o_err = stok_pkg::ERR_OPEN_COMMENT; halted_next = 1'b1;
          mode_next = stok_pkg::MODE_IDLE;
        end else if (b == 8'h0a) begin
          o_nl = 1'b1;
          mode_next = stok_pkg::MODE_BLOCK;
        end else if (mode == stok_pkg::MODE_BSTAR && b == "/") begin
          mode_next = stok_pkg::MODE_IDLE;
        end else begin
          mode_next = (b == "*") ? stok_pkg::MODE_BSTAR : stok_pkg::MODE_BLOCK;
        end
      end
      stok_pkg::MODE_PEND: begin
        mode_next = stok_pkg::MODE_IDLE;
        if (held_byte == "/") begin
          if (!is_end && b == "*") begin
            mode_next = stok_pkg::MODE_BLOCK;
          end else begin
            o_emit = 1'b1; o_err = stok_pkg::ERR_UNKNOWN; halted_next = 1'b1;
          end
        end else if (!is_end && b == stok_pkg::CH_EQ) begin
          o_emit = 1'b1; o_kind = stok_pkg::KIND_PUNCT; o_len = OB'(2);
          o_p1 = held_byte; o_p2 = stok_pkg::CH_EQ;
        end else if (held_byte == "!") begin
          o_emit = 1'b1; o_err = stok_pkg::ERR_UNKNOWN; halted_next = 1'b1;
        end else begin
          o_emit = 1'b1; o_kind = stok_pkg::KIND_PUNCT; o_len = {{(OB-1){1'b0}}, 1'b1};
          o_p1 = held_byte;
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase
    if (do_fresh) begin
      mode_next      = f_mode;
      token_len_next = f_len;
      halted_next    = f_halt;
      if (f_num) begin
        number_acc_next = {60'd0, 4'(b - "0")};
        base_next       = stok_pkg::BASE_DEC;
      end
    end
  end

  always_comb begin
    token_begin_next      = do_fresh ? byte_offset : token_begin;
    token_line_next       = do_fresh ? line_count : token_line;
    token_line_begin_next = do_fresh ? line_offset : token_line_begin;
    held_byte_next        = (do_fresh && f_mode == stok_pkg::MODE_PEND) ? b : held_byte;
    line_count_next       = line_count;
    line_offset_next      = line_offset;
    if (o_nl || (do_fresh && f_nl)) begin
      if (!line_count[OB]) line_count_next = line_count + {{OB{1'b0}}, 1'b1};
      line_offset_next = byte_offset + {{(OB-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    rec0.kind       = o_kind;
    rec0.start      = token_begin;
    rec0.length     = o_kind == stok_pkg::KIND_ERROR ? '0 : o_len;
    rec0.value      = o_val;
    rec0.p1         = o_p1;
    rec0.p2         = o_p2;
    rec0.line       = token_line;
    rec0.line_begin = token_line_begin;
    rec0.err        = o_kind == stok_pkg::KIND_ERROR ? o_err : stok_pkg::ERR_OPEN_COMMENT;
    rec0.last       = !(do_fresh && f_emit);

    rec1.kind       = f_kind;
    rec1.start      = byte_offset;
    rec1.length     = (f_kind == stok_pkg::KIND_PUNCT) ? {{(OB-1){1'b0}}, 1'b1} : '0;
    rec1.value      = 64'd0;
    rec1.p1         = f_p1;
    rec1.p2         = 8'd0;
    rec1.line       = line_count;
    rec1.line_begin = line_offset;
    rec1.err        = f_err;
    rec1.last       = 1'b1;

    wr_n = 2'd0;
    if (accept && !halted) begin
      if (o_emit && do_fresh && f_emit) begin
        wr_n = 2'd2;
      end else if (o_emit) begin
        wr_n = 2'd1;
      end else if (do_fresh && f_emit) begin
        wr_n = 2'd1;
        rec0 = rec1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= stok_pkg::MODE_IDLE;
      base             <= stok_pkg::BASE_DEC;
      held_byte        <= 8'd0;
      token_begin      <= '0;
      token_len        <= '0;
      number_acc       <= 64'd0;
      line_count       <= {{OB{1'b0}}, 1'b1};
      line_offset      <= '0;
      byte_offset      <= '0;
      token_line       <= {{OB{1'b0}}, 1'b1};
      token_line_begin <= '0;
      halted           <= 1'b0;
    end else if (accept && !halted) begin
      mode             <= mode_next;
      base             <= base_next;
      held_byte        <= held_byte_next;
      token_begin      <= token_begin_next;
      token_len        <= token_len_next;
      number_acc       <= number_acc_next;
      line_count       <= line_count_next;
      line_offset      <= line_offset_next;
      token_line       <= token_line_next;
      token_line_begin <= token_line_begin_next;
      halted           <= halted_next;
      if (!is_end) byte_offset <= byte_offset + {{(OB-1){1'b0}}, 1'b1};
    end
  end

  stok_rq #(.WIDTH($bits(rec_t))) u_rq (
    .clk      (clk),
    .rst      (rst),
    .wr_n     (wr_n),
    .wr_data0 (rec0),
    .wr_data1 (rec1),
    .room2    (room2),
    .rd_valid (tok.valid),
    .rd_ready (tok.ready),
    .rd_data  (rd_rec)
  );

  assign tok.tok_kind     = rd_rec.kind;
  assign tok.tok_start    = rd_rec.start;
  assign tok.tok_length   = rd_rec.length;
  assign tok.int_value    = rd_rec.value;
  assign tok.punct_first  = rd_rec.p1;
  assign tok.punct_second = rd_rec.p2;
  assign tok.line_number  = rd_rec.line;
  assign tok.line_begin   = rd_rec.line_begin;
  assign tok.error_code   = rd_rec.err;
  assign tok.last         = rd_rec.last;

endmodule

[rtl/core/stok_checker.sv]
// Port-level checks on the token channel of the source tokenizer.
// Depends on stok_pkg; bound to source_tokenizer below.
module stok_checker #(
  parameter int OB = 24
) (
  input logic          clk,
  input logic          rst,
  input logic          valid,
  input logic          ready,
  input logic [2:0]    kind,
  input logic [OB-1:0] length,
  input logic [63:0]   value,
  input logic [7:0]    p2
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(kind) && $stable(length) && $stable(value))
    else $error("stalled token beat changed");

  a_final: assert property (@(posedge clk) disable iff (rst)
    valid && ready && (kind == stok_pkg::KIND_END || kind == stok_pkg::KIND_ERROR)
    |=> !valid)
    else $error("token beat after end or error");

  a_value: assert property (@(posedge clk) disable iff (rst)
    valid && kind != stok_pkg::KIND_INT |-> value == 64'd0)
    else $error("value on non-integer token");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    valid && p2 != 8'd0 |-> kind == stok_pkg::KIND_PUNCT && p2 == stok_pkg::CH_EQ &&
    length == OB'(2))
    else $error("malformed two-character operator");

endmodule

bind source_tokenizer stok_checker #(.OB(OFFSET_BITS)) u_stok_checker (
  .clk    (clk),
  .rst    (rst),
  .valid  (tok.valid),
  .ready  (tok.ready),
  .kind   (tok.tok_kind),
  .length (tok.tok_length),
  .value  (tok.int_value),
  .p2     (tok.punct_second)
);

[tb/sv/stok_token_check.sv]
`timescale 1ns / 1ps
// Token checker: watches the byte and token channels, predicts every token from the
// accepted source bytes and compares field by field. Depends on stok_pkg and the
// stok_in_if / stok_out_if interfaces.
module stok_token_check
  import stok_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  stok_in_if    src,
  stok_out_if   tok,
  output int    fail_count,
  output int    open_count
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] start;
    logic [23:0] length;
    logic [63:0] value;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [24:0] line;
    logic [23:0] lbegin;
    logic [2:0]  err;
    logic        last;
  } token_rec_t;

  token_rec_t  expected_toks[$];
  int          step_count;

  mode_t       lex_mode;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic [23:0] tok_begin;
  logic [23:0] tok_len;
  logic [63:0] num_acc;
  base_t       num_base;
  logic [24:0] line_cnt;
  logic [23:0] line_off;
  logic [23:0] byte_off;
  logic        halted;
  logic [24:0] tok_line;
  logic [23:0] tok_line_off;

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (is_digit(b)) return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function void push_token(logic [2:0] kind, logic [23:0] len, logic [63:0] val,
                           logic [7:0] p1, logic [7:0] p2, logic [2:0] err);
    token_rec_t r;
    if (step_count >= 2) return;
    r.kind = kind;
    r.start = tok_begin;
    r.length = len;
    r.value = val;
    r.p1 = p1;
    r.p2 = p2;
    r.line = tok_line;
    r.lbegin = tok_line_off;
    r.err = err;
    r.last = 1'b0;
    expected_toks.push_back(r);
    step_count++;
  endfunction

  function void halt_error(logic [2:0] code);
    push_token(KIND_ERROR, '0, '0, '0, '0, code);
    halted = 1'b1;
    lex_mode = MODE_IDLE;
    held_valid = 1'b0;
  endfunction

  function void bump_line(logic [23:0] pos);
    if (line_cnt < 25'h1000000) line_cnt = line_cnt + 1'b1;
    line_off = pos + 1'b1;
  endfunction

  function void start_token(logic [7:0] b, logic e, logic [23:0] pos);
    tok_begin = pos;
    tok_line = line_cnt;
    tok_line_off = line_off;
    tok_len = '0;
    lex_mode = MODE_IDLE;
    if (e) begin
      push_token(KIND_END, '0, '0, '0, '0, '0);
      halted = 1'b1;
    end else if (b == CH_HASH) begin
      lex_mode = MODE_LINE;
    end else if (b == " " || (b >= 8'h09 && b <= 8'h0d)) begin
      if (b == 8'h0a) bump_line(pos);
    end else if (is_alpha(b) || b == CH_UNDER) begin
      lex_mode = MODE_IDENT;
      tok_len = 24'd1;
    end else if (is_digit(b)) begin
      lex_mode = MODE_NUMBER;
      num_acc = 64'(b - "0");
      num_base = BASE_DEC;
      tok_len = 24'd1;
    end else if (b == "\"") begin
      lex_mode = MODE_STRING;
      tok_len = 24'd1;
    end else if (b == CH_EQ || b == "!" || b == "<" || b == ">" || b == "/") begin
      lex_mode = MODE_PEND;
      held_byte = b;
      held_valid = 1'b1;
    end else if (b == ";" || b == "(" || b == ")" || b == "{" || b == "}" ||
                 b == "+" || b == "-" || b == "[" || b == "]" || b == "*" ||
                 b == "%" || b == ",") begin
      push_token(KIND_PUNCT, 24'd1, '0, b, '0, '0);
    end else begin
      halt_error(ERR_UNKNOWN);
    end
  endfunction

  function void predict_step(logic [7:0] b, logic e);
    logic [23:0] pos;
    logic [7:0]  h;
    logic [63:0] mul;
    token_rec_t  r;
    int          d;
    pos = byte_off;
    step_count = 0;
    if (halted) return;
    case (lex_mode)
      MODE_IDENT: begin
        if (!e && (is_alpha(b) || is_digit(b) || b == CH_UNDER)) begin
          tok_len = tok_len + 1'b1;
        end else begin
          push_token(KIND_IDENT, tok_len, '0, '0, '0, '0);
          start_token(b, e, pos);
        end
      end
      MODE_NUMBER: begin
        if (!e && num_base == BASE_DEC && tok_len == 24'd1 && num_acc == 64'd0 &&
            (b == "x" || b == "b")) begin
          if (b == "x") num_base = BASE_HEX;
          else num_base = BASE_BIN;
          tok_len = 24'd2;
        end else begin
          d = -1;
          if (!e) begin
            if (num_base == BASE_HEX) d = hex_digit(b);
            else if (num_base == BASE_BIN) d = (b == "0" || b == "1") ? int'(b - "0") : -1;
            else d = is_digit(b) ? int'(b - "0") : -1;
          end
          if (d >= 0) begin
            mul = (num_base == BASE_HEX) ? 64'd16 : (num_base == BASE_BIN) ? 64'd2 : 64'd10;
            num_acc = num_acc * mul + 64'(d);
            tok_len = tok_len + 1'b1;
          end else begin
            push_token(KIND_INT, tok_len, num_acc, '0, '0, '0);
            start_token(b, e, pos);
          end
        end
      end
      MODE_STRING: begin
        if (e) begin
          halt_error(ERR_OPEN_STRING);
        end else if (b == "\"") begin
          tok_len = tok_len + 1'b1;
          push_token(KIND_STRING, tok_len, '0, '0, '0, '0);
          lex_mode = MODE_IDLE;
        end else if (b <= CTRL_MAX) begin
          halt_error(ERR_CONTROL);
        end else begin
          if (b == CH_BSLASH) lex_mode = MODE_ESC;
          tok_len = tok_len + 1'b1;
        end
      end
      MODE_ESC: begin
        if (!e && (b == CH_BSLASH || b == "\"" || b == "n" || b == "t")) begin
          tok_len = tok_len + 1'b1;
          lex_mode = MODE_STRING;
        end else begin
          halt_error(ERR_ESCAPE);
        end
      end
      MODE_LINE: begin
        if (e || b == 8'h0a) start_token(b, e, pos);
      end
      MODE_BLOCK, MODE_BSTAR: begin
        if (e) begin
          halt_error(ERR_OPEN_COMMENT);
        end else if (b == 8'h0a) begin
          bump_line(pos);
          lex_mode = MODE_BLOCK;
        end else if (lex_mode == MODE_BSTAR && b == "/") begin
          lex_mode = MODE_IDLE;
        end else if (b == "*") begin
          lex_mode = MODE_BSTAR;
        end else begin
          lex_mode = MODE_BLOCK;
        end
      end
      MODE_PEND: begin
        h = held_byte;
        held_valid = 1'b0;
        lex_mode = MODE_IDLE;
        if (h == "/") begin
          if (!e && b == "*") lex_mode = MODE_BLOCK;
          else halt_error(ERR_UNKNOWN);
        end else if (!e && b == CH_EQ) begin
          push_token(KIND_PUNCT, 24'd2, '0, h, CH_EQ, '0);
        end else if (h == "!") begin
          halt_error(ERR_UNKNOWN);
        end else begin
          push_token(KIND_PUNCT, 24'd1, '0, h, '0, '0);
          start_token(b, e, pos);
        end
      end
      default: start_token(b, e, pos);
    endcase
    if (!e) byte_off = byte_off + 1'b1;
    if (step_count > 0) begin
      r = expected_toks.pop_back();
      r.last = 1'b1;
      expected_toks.push_back(r);
    end
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    token_rec_t w;
    if (rst) begin
      expected_toks.delete();
      fail_count = 0;
      lex_mode = MODE_IDLE;
      held_byte = '0;
      held_valid = 1'b0;
      tok_begin = '0;
      tok_len = '0;
      num_acc = '0;
      num_base = BASE_DEC;
      line_cnt = 25'd1;
      line_off = '0;
      byte_off = '0;
      halted = 1'b0;
      tok_line = 25'd1;
      tok_line_off = '0;
    end else begin
      if (src.valid && src.ready) predict_step(src.src_byte, src.is_end);
      if (tok.valid && tok.ready) begin
        if (expected_toks.size() == 0) begin
          $error("token with no expectation waiting: kind %0d start %0h",
                 tok.tok_kind, tok.tok_start);
          fail_count++;
        end else begin
          w = expected_toks.pop_front();
          check_field("tok_kind", w.kind, tok.tok_kind);
          check_field("tok_start", w.start, tok.tok_start);
          check_field("tok_length", w.length, tok.tok_length);
          check_field("int_value", w.value, tok.int_value);
          check_field("punct_first", w.p1, tok.punct_first);
          check_field("punct_second", w.p2, tok.punct_second);
          check_field("line_number", w.line, tok.line_number);
          check_field("line_begin", w.lbegin, tok.line_begin);
          check_field("error_code", w.err, tok.error_code);
          check_field("last", w.last, tok.last);
        end
      end
    end
    open_count <= expected_toks.size();
  end

endmodule

[tb/sv/source_tokenizer_test.sv]
`timescale 1ns / 1ps
// Top of the tokenizer testbench: clock, reset, byte stimulus, token-side stalls and
// the verdict. Depends on stok_pkg, the channel interfaces, source_tokenizer and stok_token_check.
module source_tokenizer_test;
  import stok_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  stok_in_if            src_ch ();
  stok_out_if #(.OFFSET_BITS(24)) tok_ch ();

  source_tokenizer #(.OFFSET_BITS(24)) DUT (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .tok (tok_ch)
  );

  int fail_count;
  int open_count;

  stok_token_check token_check (
    .clk        (clk),
    .rst        (rst),
    .src        (src_ch),
    .tok        (tok_ch),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  logic [8:0] src_text[$];
  int         beats_sent = 0;
  int         idle_cycles = 0;

  function void add_byte(logic [7:0] b, logic e = 1'b0);
    src_text.push_back({e, b});
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function void add_token();
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: begin
        add_byte(pick("abcxyzQRS_"));
        n = $urandom_range(0, 8);
        repeat (n) add_byte(pick("abzAZ_09x"));
      end
      2: begin
        add_byte(pick("0123456789"));
        n = ($urandom_range(0, 7) == 0) ? 21 : $urandom_range(0, 5);
        repeat (n) add_byte(pick("0123456789"));
      end
      3: begin
        add_text("0x");
        n = ($urandom_range(0, 5) == 0) ? 18 : $urandom_range(0, 6);
        repeat (n) add_byte(pick("0123456789abcdefABCDEF"));
      end
      4: begin
        add_text("0b");
        n = ($urandom_range(0, 5) == 0) ? 70 : $urandom_range(0, 8);
        repeat (n) add_byte(pick("01"));
      end
      5: begin
        add_byte("\"");
        n = $urandom_range(0, 10);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: begin
              add_byte(CH_BSLASH);
              add_byte(pick("\\\"nt"));
            end
            1: add_byte(8'($urandom_range(8'h80, 8'hff)));
            default: begin
              c = 8'($urandom_range(8'h20, 8'h7e));
              if (c == "\"" || c == CH_BSLASH) c = "~";
              add_byte(c);
            end
          endcase
        end
        add_byte("\"");
      end
      6: begin
        if ($urandom_range(0, 1)) add_byte(pick(";(){}+-[]*%,=<>"));
        else begin
          add_byte(pick("=!<>"));
          add_byte(CH_EQ);
        end
      end
      7: begin
        n = $urandom_range(1, 3);
        repeat (n) add_byte(pick(" \t\n\n\013\014\r"));
      end
      8: begin
        add_byte(CH_HASH);
        n = $urandom_range(0, 8);
        repeat (n) begin
          c = 8'($urandom_range(8'h00, 8'hff));
          if (c == 8'h0a) c = " ";
          add_byte(c);
        end
        add_byte(8'h0a);
      end
      default: begin
        add_text("/*");
        n = $urandom_range(0, 8);
        repeat (n) add_byte(pick("a *\nx"));
        add_text("*/");
      end
    endcase
    if ($urandom_range(0, 1)) add_byte(" ");
  endfunction

  function void add_terminal();
    add_text(" ");
    case ($urandom_range(0, 12))
      0: ;
      1: add_text("ab");
      2: add_text("\"abc");
      3: add_text("\"a\\");
      4: add_text("/* x\n");
      5: begin
        add_text("\"a");
        add_byte(8'($urandom_range(8'h00, CTRL_MAX)));
      end
      6: add_text("\"\\q");
      7: add_byte(pick("@$`^~\200\377\000"));
      8: add_text("/x");
      9: add_text("!x");
      10: add_text("# open");
      11: add_text("<");
      default: add_text("0x1F");
    endcase
    add_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat (8) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic put(logic [8:0] c);
    src_ch.valid <= 1'b1;
    src_ch.src_byte <= c[7:0];
    src_ch.is_end <= c[8];
    @(posedge clk);
    while (!src_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text();
    int burst;
    while (src_text.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && src_text.size() > 0) begin
        put(src_text.pop_front());
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        src_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    src_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if ((src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** source_tokenizer: FAILED **");
      $finish;
    end
  end

  initial begin
    int cyc;
    int style;
    bit held;
    cyc = 0;
    style = 0;
    held = 1'b0;
    tok_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && beats_sent >= 300) begin
        held = 1'b1;
        tok_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (cyc % 100 == 0) style = $urandom_range(0, 3);
        cyc++;
        case (style)
          0: tok_ch.ready <= 1'b1;
          1: tok_ch.ready <= 1'($urandom_range(0, 1));
          2: tok_ch.ready <= ($urandom_range(0, 7) != 0);
          default: tok_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    src_ch.valid = 1'b0;
    src_ch.src_byte = '0;
    src_ch.is_end = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_text("a_Z9 _x 0 0x 0b 0xFFFFFFFFFFFFFFFFF1 18446744073709551617 0b102 0X1 ");
    add_text("\"\\\\\\\"\\n\\t~\"");
    add_byte("\"");
    add_byte(8'hff);
    add_byte(8'h80);
    add_byte("\"");
    add_text("== != <= >= <x >;(){}+-[]*%,=\t\r\n");
    add_byte(8'h0b);
    add_byte(8'h0c);
    add_text("#c");
    add_byte(8'hff);
    add_text("\n/* *\n**/x\n");
    send_text();
    drain();

    while (src_text.size() < 1100) add_token();
    add_terminal();
    send_text();
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** source_tokenizer: PASSED **");
    end else begin
      $display("** source_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule
